// ----- rtl/core/mhd_pkg.sv -----
// ----------------------------------------------------------------------------
// mhd_pkg
// Shared constants, types and the unit clamp for the magic header deframer.
// ----------------------------------------------------------------------------
package mhd_pkg;

  localparam int unsigned JOINT_COUNT = 8;
  localparam int unsigned JIDX_W = 3;
  localparam int unsigned POS_W = 7;

  localparam logic [31:0] HEADER_MAGIC = 32'h5652_4553;
  localparam logic [31:0] VERSION_JOINTS = 32'd3;
  localparam logic [31:0] VERSION_STATUS = 32'd5;

  localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(8);
  localparam logic [POS_W-1:0] JOINT_PACKET_BYTES = POS_W'(16 + 8 * JOINT_COUNT);
  localparam logic [POS_W-1:0] JOINT_DATA_END = POS_W'(8 + 8 * JOINT_COUNT);
  localparam logic [POS_W-1:0] STATUS_PACKET_BYTES = POS_W'(20);
  localparam logic [POS_W-1:0] MASK_LO_POS = POS_W'(16);
  localparam logic [POS_W-1:0] MASK_HI_POS = POS_W'(17);
  localparam logic [JIDX_W-1:0] LAST_JOINT = JIDX_W'(JOINT_COUNT - 1);

  localparam logic [63:0] POS_ONE = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] NEG_ONE = 64'hBFF0_0000_0000_0000;
  localparam logic [62:0] INF_MAG = 63'h7FF0_0000_0000_0000;
  localparam logic [62:0] ONE_MAG = 63'h3FF0_0000_0000_0000;

  localparam logic KIND_JOINT = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // per-byte events from the parser to the buffer
  typedef struct packed {
    logic              wr_en;
    logic [JIDX_W-1:0] wr_joint;
    logic [2:0]        wr_lane;
    logic [7:0]        wr_data;
    logic              mask_lo_en;
    logic              mask_hi_en;
    logic              done;
    logic              done_kind;
  } mhd_evt_t;

  // clamp a double bit pattern to [-1,1], nan kept
  function automatic logic [63:0] clamp_unit(input logic [63:0] bits);
    logic [63:0] res;
    res = bits;
    if (bits[62:0] > INF_MAG) begin
      res = bits;
    end else if (bits[62:0] > ONE_MAG) begin
      res = bits[63] ? NEG_ONE : POS_ONE;
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/mhd_parse.sv -----
// ----------------------------------------------------------------------------
// mhd_parse
// Header search over an eight byte window and payload byte placement.
// ----------------------------------------------------------------------------
module mhd_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_en,
  input  logic [7:0]         data_byte,
  output mhd_pkg::mhd_evt_t  evt
);
  import mhd_pkg::*;

  typedef enum logic {SEARCH, PAYLOAD} state_t;

  state_t            state;
  logic [7:0]        win [7];
  logic [3:0]        hcnt;
  logic [POS_W-1:0]  pos;
  logic              is_status;

  logic [31:0]       magic;
  logic [31:0]       version;
  logic              hdr_joint;
  logic              hdr_status;
  logic [POS_W-1:0]  off;
  logic [POS_W-1:0]  need;

  // header as it stands with the incoming byte as the newest one
  assign magic = {win[3], win[2], win[1], win[0]};
  assign version = {data_byte, win[6], win[5], win[4]};
  assign hdr_joint = (magic == HEADER_MAGIC) && (version == VERSION_JOINTS);
  assign hdr_status = (magic == HEADER_MAGIC) && (version == VERSION_STATUS);
  assign off = pos - HEADER_BYTES;
  assign need = is_status ? STATUS_PACKET_BYTES : JOINT_PACKET_BYTES;

  // payload events for the current byte
  always_comb begin
    evt = '0;
    evt.wr_joint = off[JIDX_W+2:3];
    evt.wr_lane = off[2:0];
    evt.wr_data = data_byte;
    evt.done_kind = is_status ? KIND_STATUS : KIND_JOINT;
    if (byte_en && state == PAYLOAD) begin
      evt.wr_en = !is_status && (pos < JOINT_DATA_END);
      evt.mask_lo_en = is_status && (pos == MASK_LO_POS);
      evt.mask_hi_en = is_status && (pos == MASK_HI_POS);
      evt.done = (pos == need - POS_W'(1));
    end
  end

  // window shift, header check and payload position
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEARCH;
      hcnt <= '0;
      pos <= '0;
      is_status <= 1'b0;
    end else if (byte_en) begin
      unique case (state)
        SEARCH: begin
          if (hcnt < 4'd7) begin
            // fill the window oldest first until seven bytes are held
            win[hcnt[2:0]] <= data_byte;
            hcnt <= hcnt + 4'd1;
          end else begin
            // drop the oldest byte, newest enters at the top
            for (int i = 0; i < 6; i++) begin
              win[i] <= win[i+1];
            end
            win[6] <= data_byte;
            if (hdr_joint || hdr_status) begin
              state <= PAYLOAD;
              pos <= HEADER_BYTES;
              is_status <= hdr_status;
              hcnt <= '0;
            end
          end
        end
        PAYLOAD: begin
          if (pos == need - POS_W'(1)) begin
            state <= SEARCH;
          end else begin
            pos <= pos + POS_W'(1);
          end
        end
        default: state <= SEARCH;
      endcase
    end
  end

endmodule

// ----- rtl/core/mhd_buf.sv -----
// ----------------------------------------------------------------------------
// mhd_buf
// Two bank joint memory, per bank status masks and the result readout.
// ----------------------------------------------------------------------------
module mhd_buf (
  input  logic               clk,
  input  logic               rst,
  input  mhd_pkg::mhd_evt_t  evt,
  output logic               wr_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [2:0]         joint_index,
  output logic [63:0]        joint_value,
  output logic [15:0]        status_mask,
  output logic               last
);
  import mhd_pkg::*;

  localparam int unsigned ADDR_W = JIDX_W + 1;

  logic [63:0]       mem [2**ADDR_W];
  logic [1:0]        full;
  logic [1:0]        bank_kind;
  logic [15:0]       bank_mask [2];
  logic              wbank;
  logic              rbank;
  logic [JIDX_W-1:0] ridx;

  logic [63:0]       rd_word;
  logic [15:0]       rd_mask;
  logic              advance;
  logic              issue;
  logic              issue_last;

  assign wr_free = !full[wbank];
  assign advance = !out_valid || out_ready;
  assign issue = advance && full[rbank];
  assign issue_last = (bank_kind[rbank] == KIND_STATUS) || (ridx == LAST_JOINT);

  // byte lane writes into the bank being filled
  always_ff @(posedge clk) begin
    if (evt.wr_en) begin
      mem[{wbank, evt.wr_joint}][evt.wr_lane*8 +: 8] <= evt.wr_data;
    end
    if (evt.mask_lo_en) begin
      bank_mask[wbank][7:0] <= evt.wr_data;
    end
    if (evt.mask_hi_en) begin
      bank_mask[wbank][15:8] <= evt.wr_data;
    end
    if (evt.done) begin
      bank_kind[wbank] <= evt.done_kind;
    end
  end

  // registered read into the output stage
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_word <= mem[{rbank, ridx}];
      rd_mask <= bank_mask[rbank];
      kind <= bank_kind[rbank];
      joint_index <= ridx;
      last <= issue_last;
    end
  end

  // bank handover between filling and readout
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= '0;
      wbank <= 1'b0;
      rbank <= 1'b0;
      ridx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= full[rbank];
      end
      if (evt.done) begin
        full[wbank] <= 1'b1;
        wbank <= !wbank;
      end
      if (issue) begin
        if (issue_last) begin
          full[rbank] <= 1'b0;
          rbank <= !rbank;
          ridx <= '0;
        end else begin
          ridx <= ridx + JIDX_W'(1);
        end
      end
    end
  end

  assign joint_value = (kind == KIND_STATUS) ? 64'd0 : clamp_unit(rd_word);
  assign status_mask = (kind == KIND_STATUS) ? rd_mask : 16'd0;

  // no write lands in a bank awaiting readout
  assert property (@(posedge clk) disable iff (rst) (evt.wr_en || evt.done) |-> !full[wbank])
    else $error("write into a full bank");
  // a status item always closes its packet
  assert property (@(posedge clk) disable iff (rst) (out_valid && kind == KIND_STATUS) |-> last)
    else $error("status item without last");
  // joint index stays within the joint count
  assert property (@(posedge clk) disable iff (rst) ridx <= LAST_JOINT)
    else $error("joint index out of range");
  // with both banks full, the write bank pointer has come round to the read bank
  assert property (@(posedge clk) disable iff (rst) (full == 2'b11) |-> (wbank == rbank))
    else $error("bank pointers out of step");

endmodule

// ----- rtl/core/magic_header_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// magic_header_packet_deframer
// Finds magic/version headers in a byte stream and emits joint or status items.
// ----------------------------------------------------------------------------
//  channel  | signals                                              | dir
//  input    | in_valid, in_ready, data_byte                        | in
//  output   | out_valid, out_ready, kind, joint_index, joint_value,| out
//           | status_mask, last                                    |
//
//  one byte is taken per cycle while in_ready is high; a joint packet's
//  eight items leave in order from the two bank joint memory's readout.
//  a finished packet holds its bank until read out; in_ready drops only
//  when the bank being filled is still waiting for readout.
//  reset clears the parser and bank flags; the memory needs no clearing.
//  output stalls hold the item in the registered read stage.
module magic_header_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [2:0]  joint_index,
  output logic [63:0] joint_value,
  output logic [15:0] status_mask,
  output logic        last
);
  import mhd_pkg::*;

  mhd_evt_t evt;
  logic     wr_free;

  assign in_ready = wr_free;

  // header search and payload placement
  mhd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .byte_en   (in_valid && in_ready),
    .data_byte (data_byte),
    .evt       (evt)
  );

  // joint memory and readout
  mhd_buf u_buf (
    .clk         (clk),
    .rst         (rst),
    .evt         (evt),
    .wr_free     (wr_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .joint_index (joint_index),
    .joint_value (joint_value),
    .status_mask (status_mask),
    .last        (last)
  );

endmodule
